// ----- src/cvh_pkg.sv -----
// Shared widths, types and arithmetic helpers for the cone vision hit test.
// Used by every module of the block; depends on nothing else.
package cvh_pkg;

	localparam int COORD_W = 16;
	localparam int SQW     = 2 * COORD_W;
	localparam int SUMW    = SQW + 2;
	localparam int DOTW    = SUMW + 1;
	localparam int HALF_W  = SUMW / 2;
	localparam int N_W     = COORD_W + SUMW;
	localparam int RT_W    = SUMW / 2;
	localparam int RM_W    = RT_W + 3;
	localparam int REACH_W = COORD_W + 1;
	localparam int LIM_W   = REACH_W + 1;
	localparam int CFG_W   = 3 * COORD_W;
	localparam int LAT     = 14 + COORD_W + RT_W;

	typedef logic [COORD_W-1:0] coord_t;
	typedef coord_t [2:0] vec_t;
	typedef logic signed [COORD_W:0] dif_t;

	typedef enum logic [1:0] {
		M_START  = 2'd0,
		M_END    = 2'd1,
		M_INTERP = 2'd2
	} mode_t;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_APEX     = 2'd0;
	localparam reg_idx_t REG_RIGHT    = 2'd1;
	localparam reg_idx_t REG_LEFT     = 2'd2;
	localparam reg_idx_t REG_CENTROID = 2'd3;

	typedef struct packed {
		vec_t              p;
		vec_t              s;
		vec_t              e;
		coord_t            radius;
		mode_t             mode;
		logic [2:0]        neg;
		coord_t [2:0]      mag;
		logic [SUMW-1:0]   dot;
		logic [SUMW-1:0]   l2;
	} fb_t;

	function automatic dif_t sdiff(input coord_t a, input coord_t b);
		return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction

	function automatic logic [SQW-1:0] square(input dif_t d);
		logic signed [2*COORD_W+1:0] pr;
		pr = d * d;
		return pr[SQW-1:0];
	endfunction

endpackage

// ----- src/cvh_front.sv -----
// Front part: ranks the vertices, picks and orients the edge, and classifies
// the projection. Depends on cvh_pkg.
module cvh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  cvh_pkg::vec_t   in_pos,
	input  cvh_pkg::coord_t in_radius,
	input  cvh_pkg::vec_t   apex,
	input  cvh_pkg::vec_t   right_v,
	input  cvh_pkg::vec_t   left_v,
	output logic          out_valid,
	output cvh_pkg::fb_t    out_item
);
	import cvh_pkg::*;

	localparam logic [1:0] V_APEX  = 2'd0;
	localparam logic [1:0] V_RIGHT = 2'd1;
	localparam logic [1:0] V_LEFT  = 2'd2;

	typedef logic signed [COORD_W+2:0] sum_t;

	vec_t vtx [3];
	assign vtx[0] = apex;
	assign vtx[1] = right_v;
	assign vtx[2] = left_v;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	vec_t p_s1, p_s2, p_s3, p_s4, p_s5;
	coord_t r_s1, r_s2, r_s3, r_s4, r_s5;
	logic [SQW-1:0] sq_s1 [3][3];
	logic [1:0] si_s2, ei_s2;
	vec_t s_s3, e_s3, s_s4, e_s4, s_s5, e_s5;
	dif_t d_s4 [3];
	dif_t ps_s4 [3];
	logic [SQW-1:0] dd_s5 [3];
	logic signed [SQW+1:0] pd_s5 [3];
	logic [2:0] neg_s5;
	coord_t [2:0] mag_s5;

	function automatic vec_t pick(input logic [1:0] idx, input vec_t a, input vec_t b,
			input vec_t c);
		case (idx)
			V_APEX:  return a;
			V_RIGHT: return b;
			default: return c;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: squared component distances to each vertex.
	always_ff @(posedge clk) begin
		p_s1 <= in_pos;
		r_s1 <= in_radius;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[i][k] <= square(sdiff(in_pos[k], vtx[i][k]));
			end
		end
	end

	// Stage 2: stable ranking; ties keep apex, right, left order.
	logic [SUMW-1:0] rk [3];
	logic [1:0] pos0, pos1, si_c, ei_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rk[i] = SUMW'(sq_s1[i][0]) + SUMW'(sq_s1[i][1]) + SUMW'(sq_s1[i][2]);
		end
		pos0 = {1'b0, rk[1] < rk[0]} + {1'b0, rk[2] < rk[0]};
		pos1 = {1'b0, rk[0] <= rk[1]} + {1'b0, rk[2] < rk[1]};
		si_c = (pos0 == 2'd0) ? V_APEX : (pos1 == 2'd0) ? V_RIGHT : V_LEFT;
		ei_c = (pos0 == 2'd1) ? V_APEX : (pos1 == 2'd1) ? V_RIGHT : V_LEFT;
	end

	always_ff @(posedge clk) begin
		p_s2  <= p_s1;
		r_s2  <= r_s1;
		si_s2 <= si_c;
		ei_s2 <= ei_c;
	end

	// Stage 3: apex first, then swap again when the edge's component sum is negative.
	vec_t sa, ea, sb, eb;
	sum_t esum;

	always_comb begin
		sa = pick(si_s2, apex, right_v, left_v);
		ea = pick(ei_s2, apex, right_v, left_v);
		if (sa != apex && ea == apex) begin
			sb = ea;
			eb = sa;
		end else begin
			sb = sa;
			eb = ea;
		end
		esum = sum_t'(sdiff(eb[0], sb[0])) + sum_t'(sdiff(eb[1], sb[1]))
			+ sum_t'(sdiff(eb[2], sb[2]));
	end

	always_ff @(posedge clk) begin
		p_s3 <= p_s2;
		r_s3 <= r_s2;
		if (esum < 0) begin
			s_s3 <= eb;
			e_s3 <= sb;
		end else begin
			s_s3 <= sb;
			e_s3 <= eb;
		end
	end

	// Stage 4: edge vector and offset of the point from the edge start.
	always_ff @(posedge clk) begin
		p_s4 <= p_s3;
		r_s4 <= r_s3;
		s_s4 <= s_s3;
		e_s4 <= e_s3;
		for (int k = 0; k < 3; k++) begin
			d_s4[k]  <= sdiff(e_s3[k], s_s3[k]);
			ps_s4[k] <= sdiff(p_s3[k], s_s3[k]);
		end
	end

	// Stage 5: products for the squared length and the dot product, plus edge signs and magnitudes.
	dif_t nd [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nd[k] = -d_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		p_s5 <= p_s4;
		r_s5 <= r_s4;
		s_s5 <= s_s4;
		e_s5 <= e_s4;
		for (int k = 0; k < 3; k++) begin
			dd_s5[k]  <= square(d_s4[k]);
			pd_s5[k]  <= ps_s4[k] * d_s4[k];
			neg_s5[k] <= d_s4[k][COORD_W];
			mag_s5[k] <= d_s4[k][COORD_W] ? nd[k][COORD_W-1:0] : d_s4[k][COORD_W-1:0];
		end
	end

	// Sums and classification, handed straight to the queue.
	logic [SUMW-1:0] l2;
	logic signed [DOTW-1:0] dot;

	always_comb begin
		l2  = SUMW'(dd_s5[0]) + SUMW'(dd_s5[1]) + SUMW'(dd_s5[2]);
		dot = DOTW'(pd_s5[0]) + DOTW'(pd_s5[1]) + DOTW'(pd_s5[2]);
		out_item.p      = p_s5;
		out_item.s      = s_s5;
		out_item.e      = e_s5;
		out_item.radius = r_s5;
		out_item.neg    = neg_s5;
		out_item.mag    = mag_s5;
		out_item.dot    = dot[SUMW-1:0];
		out_item.l2     = l2;
		if (l2 == '0 || dot < 0) begin
			out_item.mode = M_START;
		end else if (dot > $signed({1'b0, l2})) begin
			out_item.mode = M_END;
		end else begin
			out_item.mode = M_INTERP;
		end
	end

	assign out_valid = v_s5;

endmodule

// ----- src/cvh_queue.sv -----
// Two-entry queue between the front and back parts.
// Depends on cvh_pkg for the item type.
module cvh_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cvh_pkg::fb_t  push_item,
	output logic        full,
	output logic        pop_valid,
	output cvh_pkg::fb_t  pop_item
);
	import cvh_pkg::*;

	fb_t mem [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic pop;

	// The back part never stalls, so an entry leaves as soon as it is there.
	assign pop       = (cnt_q != 2'd0);
	assign pop_valid = pop;
	assign full      = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	assign pop_item = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- src/cvh_back.sv -----
// Back part: projection divide, closest point, centroid distance root and hit compare.
// Depends on cvh_pkg.
module cvh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  cvh_pkg::fb_t    in_item,
	input  cvh_pkg::vec_t   centroid,
	output logic          out_valid,
	output logic          out_hit,
	output logic [cvh_pkg::REACH_W-1:0] out_reach
);
	import cvh_pkg::*;

	typedef struct packed {
		vec_t            p;
		vec_t            s;
		vec_t            e;
		coord_t          radius;
		mode_t           mode;
		logic [2:0]      neg;
		logic [SUMW-1:0] l2;
	} bk_t;

	typedef struct packed {
		logic [SUMW-1:0] rem;
		coord_t          low;
		coord_t          q;
	} lane_t;

	typedef struct packed {
		logic [RM_W-1:0] rem;
		logic [RT_W-1:0] root;
		logic [SUMW-1:0] x;
	} rt_t;

	function automatic lane_t div_step(input lane_t a, input logic [SUMW-1:0] den);
		logic [SUMW:0] pre;
		logic [SUMW:0] dif;
		lane_t r;
		pre = {a.rem, a.low[COORD_W-1]};
		dif = pre - {1'b0, den};
		r.low = {a.low[COORD_W-2:0], 1'b0};
		if (pre >= {1'b0, den}) begin
			r.rem = dif[SUMW-1:0];
			r.q   = {a.q[COORD_W-2:0], 1'b1};
		end else begin
			r.rem = pre[SUMW-1:0];
			r.q   = {a.q[COORD_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic rt_t rt_step(input rt_t a);
		logic [RM_W-1:0] pre;
		logic [RM_W-1:0] trial;
		rt_t r;
		pre   = {a.rem[RM_W-3:0], a.x[SUMW-1 -: 2]};
		trial = RM_W'({a.root, 2'b01});
		r.x   = {a.x[SUMW-3:0], 2'b00};
		if (pre >= trial) begin
			r.rem  = pre - trial;
			r.root = {a.root[RT_W-2:0], 1'b1};
		end else begin
			r.rem  = pre;
			r.root = {a.root[RT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Stage 1: mag * dot as two partial products.
	logic v_s1;
	bk_t it_s1;
	logic [COORD_W+HALF_W-1:0] pl_s1 [3];
	logic [COORD_W+SUMW-HALF_W-1:0] ph_s1 [3];

	always_ff @(posedge clk) begin
		it_s1.p      <= in_item.p;
		it_s1.s      <= in_item.s;
		it_s1.e      <= in_item.e;
		it_s1.radius <= in_item.radius;
		it_s1.mode   <= in_item.mode;
		it_s1.neg    <= in_item.neg;
		it_s1.l2     <= in_item.l2;
		for (int k = 0; k < 3; k++) begin
			pl_s1[k] <= in_item.mag[k] * in_item.dot[HALF_W-1:0];
			ph_s1[k] <= in_item.mag[k] * in_item.dot[SUMW-1:HALF_W];
		end
	end

	// Restoring divider, one quotient bit per stage for each lane.
	logic  dv_v_s  [COORD_W+1];
	bk_t   dv_it_s [COORD_W+1];
	lane_t dv_ln_s [COORD_W+1][3];
	logic [N_W-1:0] num [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = N_W'(pl_s1[k]) + (N_W'(ph_s1[k]) << HALF_W);
		end
	end

	always_ff @(posedge clk) begin
		dv_it_s[0] <= it_s1;
		for (int k = 0; k < 3; k++) begin
			dv_ln_s[0][k].rem <= num[k][N_W-1:COORD_W];
			dv_ln_s[0][k].low <= num[k][COORD_W-1:0];
			dv_ln_s[0][k].q   <= '0;
		end
	end

	for (genvar j = 0; j < COORD_W; j++) begin : g_div
		always_ff @(posedge clk) begin
			dv_it_s[j+1] <= dv_it_s[j];
			for (int k = 0; k < 3; k++) begin
				dv_ln_s[j+1][k] <= div_step(dv_ln_s[j][k], dv_it_s[j].l2);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end
	end

	// Round half up and form the closest edge point.
	bk_t   dq;
	vec_t  cpt;
	logic  rbit;
	logic signed [COORD_W+1:0] off;
	logic signed [COORD_W+1:0] sum;

	always_comb begin
		dq = dv_it_s[COORD_W];
		for (int k = 0; k < 3; k++) begin
			rbit = ({dv_ln_s[COORD_W][k].rem, 1'b0} >= {1'b0, dq.l2});
			off  = $signed({2'b00, dv_ln_s[COORD_W][k].q}) + $signed({{(COORD_W+1){1'b0}}, rbit});
			sum  = $signed({{2{dq.s[k][COORD_W-1]}}, dq.s[k]}) + (dq.neg[k] ? -off : off);
			unique case (dq.mode)
				M_START:  cpt[k] = dq.s[k];
				M_END:    cpt[k] = dq.e[k];
				M_INTERP: cpt[k] = sum[COORD_W-1:0];
				default:  cpt[k] = dq.s[k];
			endcase
		end
	end

	logic v_c, v_q;
	vec_t c_c, p_c;
	coord_t rad_c, rad_q;
	logic [SQW-1:0] cd_q [3];
	logic [SQW-1:0] pc_q [3];

	always_ff @(posedge clk) begin
		c_c   <= cpt;
		p_c   <= dq.p;
		rad_c <= dq.radius;
		rad_q <= rad_c;
		for (int k = 0; k < 3; k++) begin
			cd_q[k] <= square(sdiff(c_c[k], centroid[k]));
			pc_q[k] <= square(sdiff(p_c[k], c_c[k]));
		end
	end

	// Square root, one result bit per stage.
	logic            sr_v_s   [RT_W+1];
	rt_t             sr_rt_s  [RT_W+1];
	logic [SUMW-1:0] sr_len_s [RT_W+1];
	coord_t          sr_rad_s [RT_W+1];

	always_ff @(posedge clk) begin
		sr_rt_s[0].rem  <= '0;
		sr_rt_s[0].root <= '0;
		sr_rt_s[0].x    <= SUMW'(cd_q[0]) + SUMW'(cd_q[1]) + SUMW'(cd_q[2]);
		sr_len_s[0]     <= SUMW'(pc_q[0]) + SUMW'(pc_q[1]) + SUMW'(pc_q[2]);
		sr_rad_s[0]     <= rad_q;
	end

	for (genvar j = 0; j < RT_W; j++) begin : g_rt
		always_ff @(posedge clk) begin
			sr_rt_s[j+1]  <= rt_step(sr_rt_s[j]);
			sr_len_s[j+1] <= sr_len_s[j];
			sr_rad_s[j+1] <= sr_rad_s[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v_s[j+1] <= 1'b0;
			end else begin
				sr_v_s[j+1] <= sr_v_s[j];
			end
		end
	end

	// Round to nearest: the remainder is x - root^2.
	logic [RT_W:0] rnd;
	logic v_r, v_l;
	logic [REACH_W-1:0] reach_r, reach_l;
	logic [SUMW-1:0] len_r, len_l;
	coord_t rad_r;
	logic [2*LIM_W-1:0] lsq_l;
	logic [LIM_W-1:0] lim;

	always_comb begin
		rnd = {1'b0, sr_rt_s[RT_W].root}
			+ {{RT_W{1'b0}}, (sr_rt_s[RT_W].rem > RM_W'(sr_rt_s[RT_W].root))};
		lim = LIM_W'(rad_r) + LIM_W'(reach_r);
	end

	always_ff @(posedge clk) begin
		reach_r <= (rnd > (RT_W+1)'({REACH_W{1'b1}})) ? {REACH_W{1'b1}} : rnd[REACH_W-1:0];
		len_r   <= sr_len_s[RT_W];
		rad_r   <= sr_rad_s[RT_W];
		lsq_l   <= lim * lim;
		len_l   <= len_r;
		reach_l <= reach_r;
		out_hit   <= ((2*LIM_W)'(len_l) < lsq_l);
		out_reach <= reach_l;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			dv_v_s[0] <= 1'b0;
			v_c       <= 1'b0;
			v_q       <= 1'b0;
			sr_v_s[0] <= 1'b0;
			v_r       <= 1'b0;
			v_l       <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			dv_v_s[0] <= v_s1;
			v_c       <= dv_v_s[COORD_W];
			v_q       <= v_c;
			sr_v_s[0] <= v_q;
			v_r       <= sr_v_s[RT_W];
			v_l       <= v_r;
			out_valid <= v_l;
		end
	end

endmodule

// ----- src/cone_vision_hit_test.sv -----
// Top level of the cone vision hit test: configuration registers, front part,
// queue and back part. Depends on cvh_pkg, cvh_front, cvh_queue and cvh_back.
//
// Usage:
//   Configuration: write apex, right, left and centroid (three packed signed
//   coordinates each, x in the low bits) through cfg_valid/cfg_ready with
//   cfg_index and cfg_data. cfg_ready is always high; write only while idle.
//   Queries: a transaction is accepted at a rising edge with start high and
//   busy low. pos_x, pos_y, pos_z and obj_radius are sampled then.
//   Results: done is high for exactly one cycle with hit and reach_radius.
//   The receiver cannot stall; every query yields one result.
//   The pipeline from acceptance to done is set by the bit-per-stage projection
//   divider and the bit-per-stage square root.
//   Throughput is one query per cycle while busy is low; the queue between
//   front and back keeps busy low in normal operation.
//   Reset clears the configuration to zero and empties the pipeline.
module cone_vision_hit_test (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [cvh_pkg::COORD_W-1:0] pos_x,
	input  logic signed [cvh_pkg::COORD_W-1:0] pos_y,
	input  logic signed [cvh_pkg::COORD_W-1:0] pos_z,
	input  logic [cvh_pkg::COORD_W-1:0]        obj_radius,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  cvh_pkg::reg_idx_t                cfg_index,
	input  logic [cvh_pkg::CFG_W-1:0]          cfg_data,
	output logic                             done,
	output logic                             hit,
	output logic [cvh_pkg::REACH_W-1:0]        reach_radius
);
	import cvh_pkg::*;

	vec_t apex_q, right_q, left_q, centroid_q;
	vec_t in_pos;
	logic fr_valid, q_full, q_valid;
	fb_t fr_item, q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apex_q     <= '0;
			right_q    <= '0;
			left_q     <= '0;
			centroid_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_APEX:     apex_q     <= cfg_data;
				REG_RIGHT:    right_q    <= cfg_data;
				REG_LEFT:     left_q     <= cfg_data;
				REG_CENTROID: centroid_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign in_pos = {pos_z, pos_y, pos_x};
	assign busy   = q_full;

	cvh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_pos    (in_pos),
		.in_radius (obj_radius),
		.apex      (apex_q),
		.right_v   (right_q),
		.left_v    (left_q),
		.out_valid (fr_valid),
		.out_item  (fr_item)
	);

	cvh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid),
		.push_item (fr_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	cvh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.centroid  (centroid_q),
		.out_valid (done),
		.out_hit   (hit),
		.out_reach (reach_radius)
	);

endmodule

// ----- src/cvh_checker.sv -----
// Port-level checks for the cone vision hit test, bound to the top level.
// Depends on cvh_pkg and cone_vision_hit_test.
module cvh_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        done
);
	import cvh_pkg::*;

	// Every accepted query comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted query did not produce a result on time");

	// The back part never stalls, so the queue never fills.
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the back part drains every cycle");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind cone_vision_hit_test cvh_checker u_chk (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for cone_vision_hit_test: a scoreboard class predicts each
// result from the configured cone, and tasks drive queries and register writes.
// Depends on cvh_pkg and the cone_vision_hit_test RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cvh_pkg::*;

	typedef struct {
		logic               hit;
		logic [REACH_W-1:0] reach;
	} cone_result_t;

	class cone_scoreboard;
		longint vert[3][3];
		longint cen[3];
		cone_result_t pending[$];
		int fails;

		function longint sx(logic [COORD_W-1:0] v);
			return longint'($signed(v));
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
			for (int k = 0; k < 3; k++) begin
				if (idx == REG_CENTROID)
					cen[k] = sx(d[k*COORD_W +: COORD_W]);
				else
					vert[idx][k] = sx(d[k*COORD_W +: COORD_W]);
			end
		endfunction

		function longint unsigned sq_dist(longint a[3], longint b[3]);
			longint unsigned s;
			s = 0;
			for (int k = 0; k < 3; k++)
				s += longint'((a[k] - b[k]) * (a[k] - b[k]));
			return s;
		endfunction

		function longint unsigned root_nearest(longint unsigned x);
			longint unsigned r, b, v;
			r = 0;
			v = x;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			if (x - r * r > r)
				r++;
			return r;
		endfunction

		function void note_query(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
				logic [COORD_W-1:0] pz, logic [COORD_W-1:0] rad);
			longint p[3], s[3], e[3], d[3], c[3], t[3];
			longint unsigned rank[3], reach, lim, len2, mag, q, rm, prod;
			int ord[3];
			int tmp;
			longint sum, dot, l2;
			cone_result_t res;
			p[0] = sx(px);
			p[1] = sx(py);
			p[2] = sx(pz);
			ord = '{0, 1, 2};
			for (int i = 0; i < 3; i++)
				rank[i] = sq_dist(p, vert[i]);
			// Stable bubble sort so that ties keep apex, right, left.
			for (int i = 0; i < 2; i++)
				for (int j = 2; j > i; j--)
					if (rank[ord[j]] < rank[ord[j-1]]) begin
						tmp = ord[j];
						ord[j] = ord[j-1];
						ord[j-1] = tmp;
					end
			s = vert[ord[0]];
			e = vert[ord[1]];
			if (s != vert[0] && e == vert[0]) begin
				t = s;
				s = e;
				e = t;
			end
			sum = 0;
			for (int k = 0; k < 3; k++)
				sum += e[k] - s[k];
			if (sum < 0) begin
				t = s;
				s = e;
				e = t;
			end
			dot = 0;
			l2 = 0;
			for (int k = 0; k < 3; k++) begin
				d[k] = e[k] - s[k];
				l2 += d[k] * d[k];
				dot += (p[k] - s[k]) * d[k];
			end
			if (l2 == 0 || dot < 0) begin
				c = s;
			end else if (dot > l2) begin
				c = e;
			end else begin
				for (int k = 0; k < 3; k++) begin
					mag = (d[k] < 0) ? -d[k] : d[k];
					prod = mag * longint'(dot);
					q = prod / longint'(l2);
					rm = prod % longint'(l2);
					if (rm >= longint'(l2) - rm)
						q++;
					c[k] = s[k] + ((d[k] < 0) ? -longint'(q) : longint'(q));
				end
			end
			reach = root_nearest(sq_dist(c, cen));
			if (reach > (64'd1 << REACH_W) - 1)
				reach = (64'd1 << REACH_W) - 1;
			len2 = sq_dist(p, c);
			lim = rad + reach;
			res.hit = (len2 < lim * lim);
			res.reach = reach[REACH_W-1:0];
			pending.insert(pending.size(), res);
		endfunction

		function void check_result(logic h, logic [REACH_W-1:0] r);
			cone_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result hit=%0d reach_radius=%0d", $time, h, r);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (h !== want.hit) begin
				$display("%0t: hit expected %0d actual %0d", $time, want.hit, h);
				fails++;
			end
			if (r !== want.reach) begin
				$display("%0t: reach_radius expected %0d actual %0d", $time, want.reach, r);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
	logic [COORD_W-1:0] obj_radius;
	logic cfg_valid;
	logic cfg_ready;
	reg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic done;
	logic hit;
	logic [REACH_W-1:0] reach_radius;

	cone_scoreboard sb;
	int idle_cycles;
	bit no_gaps;
	logic [CFG_W-1:0] cone_regs[4];

	cone_vision_hit_test u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (done)
			sb.check_result(hit, reach_radius);
		if ((start && !busy) || done || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return;
		repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(5, 40)) @(negedge clk);
	endtask

	// Inputs are driven at the falling edge; busy is stable there, so a query that
	// sees busy low is accepted at the following rising edge.
	task automatic send_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z, logic [COORD_W-1:0] r);
		pos_x = x;
		pos_y = y;
		pos_z = z;
		obj_radius = r;
		start = 1'b1;
		while (busy)
			@(negedge clk);
		sb.note_query(x, y, z, r);
		@(negedge clk);
		start = 1'b0;
		idle_gap();
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1'b1;
		while (!cfg_ready)
			@(negedge clk);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (LAT + 10) @(negedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord(bit narrow);
		return narrow ? COORD_W'($signed($urandom_range(0, 4000)) - 2000)
			: COORD_W'($urandom);
	endfunction

	function automatic logic [CFG_W-1:0] rand_vec(bit narrow);
		return {rand_coord(narrow), rand_coord(narrow), rand_coord(narrow)};
	endfunction

	task automatic load_cone(logic [CFG_W-1:0] a, logic [CFG_W-1:0] rt,
			logic [CFG_W-1:0] lf, logic [CFG_W-1:0] c);
		cone_regs = '{a, rt, lf, c};
		write_reg(REG_APEX, a);
		write_reg(REG_RIGHT, rt);
		write_reg(REG_LEFT, lf);
		write_reg(REG_CENTROID, c);
	endtask

	// Most queries land near a vertex or the centroid of the cone so that every edge and clamp
	// case is reached; the rest are anywhere in the coordinate range, or within -2000..2000 in narrow phases.
	task automatic random_query(bit narrow);
		logic [CFG_W-1:0] v;
		logic [COORD_W-1:0] x, y, z, r;
		v = cone_regs[$urandom_range(0, 3)];
		if ($urandom_range(0, 3) != 0) begin
			x = v[0 +: COORD_W] + rand_coord(1);
			y = v[COORD_W +: COORD_W] + rand_coord(1);
			z = v[2*COORD_W +: COORD_W] + rand_coord(1);
		end else begin
			x = rand_coord(narrow);
			y = rand_coord(narrow);
			z = rand_coord(narrow);
		end
		r = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 800));
		send_query(x, y, z, r);
	endtask

	localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

	initial begin
		sb = new();
		idle_cycles = 0;
		no_gaps = 0;
		cone_regs = '{default: '0};
		start = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		obj_radius = 0;
		cfg_valid = 0;
		cfg_index = REG_APEX;
		cfg_data = '0;
		arst_n = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset cone: every edge has zero length.
		send_query(0, 0, 0, 0);
		send_query(CMAX, CMIN, CMAX, 16'hffff);
		drain();
		// A simple triangle: projections before the start, beyond the end and inside.
		load_cone({16'd0, 16'd0, 16'd0}, {16'd0, 16'd0, 16'd320}, {16'd0, 16'd320, 16'd0},
			{16'd0, 16'd100, 16'd100});
		send_query(16'd160, 16'd0, 16'd0, 16'd0);
		send_query(-16'sd50, -16'sd50, 16'd0, 16'd20);
		send_query(16'd400, 16'd0, 16'd0, 16'd10);
		send_query(16'd160, 16'd160, 16'd0, 16'd1);
		send_query(16'd0, 16'd160, 16'd0, 16'd0);
		send_query(16'd0, 16'd160, 16'd50, 16'd300);
		// Equidistant point: a tie between right and left.
		send_query(16'd320, 16'd320, 16'd0, 16'd5);
		drain();
		// Coincident vertices, right equal to apex.
		load_cone({16'd10, 16'd10, 16'd10}, {16'd10, 16'd10, 16'd10},
			{-16'sd100, -16'sd100, 16'd40}, {16'd0, 16'd0, 16'd0});
		send_query(16'd10, 16'd10, 16'd10, 16'd0);
		send_query(-16'sd90, 16'd0, 16'd0, 16'd7);
		send_query(16'd500, 16'd500, 16'd500, 16'd3);
		drain();
		// Extreme coordinates at the ends of the signed range.
		load_cone({CMIN, CMIN, CMIN}, {CMAX, CMAX, CMAX}, {CMIN, CMAX, CMIN},
			{CMAX, CMIN, CMAX});
		send_query(CMAX, CMAX, CMAX, 16'hffff);
		send_query(CMIN, CMIN, CMIN, 16'h0000);
		send_query(CMIN, CMAX, CMAX, 16'h8000);
		send_query(CMAX, CMIN, CMIN, 16'h7fff);
		send_query(16'd0, 16'd0, 16'd0, 16'd1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			bit narrow;
			narrow = (ph % 3 != 2);
			no_gaps = (ph == 3);
			load_cone(rand_vec(narrow), rand_vec(narrow), rand_vec(narrow), rand_vec(narrow));
			repeat (128) random_query(narrow);
			drain();
		end

		if (sb.fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ----- cone_vision_hit_test.f -----
src/cvh_pkg.sv
src/cvh_front.sv
src/cvh_queue.sv
src/cvh_back.sv
src/cone_vision_hit_test.sv
src/cvh_checker.sv
tb/tb.sv
